### design/sname_pkg.sv
// Shared types, constants and helpers for the 8.3 short name formatter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package sname_pkg;

	localparam int BASE_LEN = 8;
	localparam int EXT_LEN  = 3;
	localparam int BASE_W   = 8 * BASE_LEN;
	localparam int EXT_W    = 8 * EXT_LEN;
	localparam int CFG_W    = 64;
	localparam int BCNT_W   = 4;
	localparam int ECNT_W   = 3;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	localparam logic [BASE_W-1:0] SPACES_BASE = {BASE_LEN{CHAR_SPACE}};
	localparam logic [EXT_W-1:0]  SPACES_EXT  = {EXT_LEN{CHAR_SPACE}};

	localparam logic [BCNT_W-1:0] BCNT_MAX = BCNT_W'(BASE_LEN + 1);
	localparam logic [ECNT_W-1:0] ECNT_MAX = ECNT_W'(EXT_LEN + 1);

	// Configuration register indexes.
	localparam logic CFG_TARGET_BASE = 1'b0;
	localparam logic CFG_TARGET_EXT  = 1'b1;

	// One finished short name as it leaves the accumulator.
	typedef struct packed {
		logic              valid_res;
		logic [BASE_W-1:0] base_name;
		logic [EXT_W-1:0]  ext_name;
		logic              matches_res;
	} result_t;

	// Raises ASCII a-z to A-Z and leaves every other byte alone.
	function automatic logic [7:0] raise_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
			r = c - CASE_DIFF;
		end
		return r;
	endfunction

endpackage

### design/short_name_formatter.sv
// FAT 8.3 short name formatter, top level. Uses sname_pkg, sname_accum, sname_outreg.
// A last byte goes from the byte register into the result register, which drives the ports.
// One byte per cycle while in_stall is low; the byte and result registers each hold one.
// Reset (arst_n, asynchronous, active low): empties both registers, clears the
// name being built and sets both target registers to spaces.
`timescale 1ns / 1ps

module short_name_formatter import sname_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Byte channel.
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        name_char,
	input  logic              is_last,
	// Result channel.
	output logic              out_valid,
	input  logic              out_stall,
	output logic              valid_res,
	output logic [BASE_W-1:0] base_name,
	output logic [EXT_W-1:0]  ext_name,
	output logic              matches_res,
	// Configuration write channel.
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// Input stage: one accepted byte waits here while the accumulator takes it in.
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;

	// Target name registers.
	logic [BASE_W-1:0] target_base_q;
	logic [EXT_W-1:0]  target_ext_q;

	logic              adv_s1;
	logic              can_load;
	logic              in_take;
	result_t           acc_result;
	result_t           out_result;

	// A byte that does not end a name leaves the input stage at once. A last byte
	// must also find room in the result register, which frees up as the consumer
	// takes its request, so a new byte is accepted in the same cycle.
	assign adv_s1   = valid_s1 && (!last_s1 || can_load);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= name_char;
			last_s1 <= is_last;
		end
	end

	// Configuration writes are always taken; the user must write only while idle (unenforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_base_q <= SPACES_BASE;
			target_ext_q  <= SPACES_EXT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TARGET_BASE: target_base_q <= cfg_data;
				CFG_TARGET_EXT:  target_ext_q  <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	sname_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv_s1),
		.name_char   (char_s1),
		.is_last     (last_s1),
		.target_base (target_base_q),
		.target_ext  (target_ext_q),
		.result      (acc_result)
	);

	// Only a last byte produces a request on the result channel.
	sname_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1 && last_s1),
		.result_in  (acc_result),
		.out_stall  (out_stall),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.result_out (out_result)
	);

	assign valid_res   = out_result.valid_res;
	assign base_name   = out_result.base_name;
	assign ext_name    = out_result.ext_name;
	assign matches_res = out_result.matches_res;

endmodule

### design/sname_accum.sv
// Per-name accumulator: keeps the base and extension buffers and counts,
// takes one byte per advance and forms the result on the last byte. Uses sname_pkg.
`timescale 1ns / 1ps

module sname_accum import sname_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        name_char,
	input  logic              is_last,
	input  logic [BASE_W-1:0] target_base,
	input  logic [EXT_W-1:0]  target_ext,
	output result_t           result
);

	logic [BASE_W-1:0] base_q, base_d;
	logic [EXT_W-1:0]  ext_q, ext_d;
	logic [BCNT_W-1:0] bcnt_q, bcnt_d;
	logic [ECNT_W-1:0] ecnt_q, ecnt_d;
	logic              dot_q, dot_d;
	logic              term_q, term_d;
	logic [7:0]        up_char;
	logic              name_ok;

	assign up_char = raise_case(name_char);

	// Next state after taking in one byte.
	always_comb begin
		base_d = base_q;
		ext_d  = ext_q;
		bcnt_d = bcnt_q;
		ecnt_d = ecnt_q;
		dot_d  = dot_q;
		term_d = term_q;
		if (!term_q) begin
			if (name_char == CHAR_NUL) begin
				term_d = 1'b1;
			end else if (!dot_q && name_char == CHAR_DOT) begin
				dot_d = 1'b1;
			end else if (!dot_q) begin
				for (int i = 0; i < BASE_LEN; i++) begin
					if (bcnt_q == BCNT_W'(i)) begin
						base_d[BASE_W-1-8*i -: 8] = up_char;
					end
				end
				if (bcnt_q < BCNT_MAX) begin
					bcnt_d = bcnt_q + 1'b1;
				end
			end else begin
				for (int i = 0; i < EXT_LEN; i++) begin
					if (ecnt_q == ECNT_W'(i)) begin
						ext_d[EXT_W-1-8*i -: 8] = up_char;
					end
				end
				if (ecnt_q < ECNT_MAX) begin
					ecnt_d = ecnt_q + 1'b1;
				end
			end
		end
	end

	// The result is formed from the state that includes the last byte.
	always_comb begin
		name_ok = (bcnt_d != '0) && (bcnt_d <= BCNT_W'(BASE_LEN))
			&& (ecnt_d <= ECNT_W'(EXT_LEN));
		result.valid_res   = name_ok;
		result.base_name   = name_ok ? base_d : SPACES_BASE;
		result.ext_name    = name_ok ? ext_d : SPACES_EXT;
		result.matches_res = name_ok && (base_d == target_base) && (ext_d == target_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= SPACES_BASE;
			ext_q  <= SPACES_EXT;
			bcnt_q <= '0;
			ecnt_q <= '0;
			dot_q  <= 1'b0;
			term_q <= 1'b0;
		end else if (adv) begin
			if (is_last) begin
				base_q <= SPACES_BASE;
				ext_q  <= SPACES_EXT;
				bcnt_q <= '0;
				ecnt_q <= '0;
				dot_q  <= 1'b0;
				term_q <= 1'b0;
			end else begin
				base_q <= base_d;
				ext_q  <= ext_d;
				bcnt_q <= bcnt_d;
				ecnt_q <= ecnt_d;
				dot_q  <= dot_d;
				term_q <= term_d;
			end
		end
	end

endmodule

### design/sname_outreg.sv
// Result register: holds one finished short name until the consumer takes it.
// Uses result_t from sname_pkg.
`timescale 1ns / 1ps

module sname_outreg import sname_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_in,
	input  logic    out_stall,
	output logic    can_load,
	output logic    out_valid,
	output result_t result_out
);

	logic    valid_q;
	result_t data_q;

	// A new result may enter when the register is empty or is being taken.
	assign can_load   = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign result_out = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_in;
		end
	end

endmodule

### design/sname_checker.sv
// Port-level checks for short_name_formatter, attached by the bind below.
// Uses constants from sname_pkg.
`timescale 1ns / 1ps

module sname_checker import sname_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              valid_res,
	input logic [BASE_W-1:0] base_name,
	input logic [EXT_W-1:0]  ext_name,
	input logic              matches_res
);

	// A stalled request stays offered with the same name.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(base_name) && $stable(ext_name))
		else $error("stalled result request changed");

	// A match is only reported for a name that fits the 8.3 rules.
	a_match_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matches_res |-> valid_res)
		else $error("match reported on an invalid name");

	// An invalid name is reported as all spaces.
	a_invalid_spaces: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> base_name == SPACES_BASE && ext_name == SPACES_EXT)
		else $error("invalid name not blanked");

	// A valid name always has a first base byte, which is never a dot.
	a_base_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> base_name[BASE_W-1 -: 8] != CHAR_DOT)
		else $error("valid name starts with a dot");

endmodule

bind short_name_formatter sname_checker u_sname_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.valid_res   (valid_res),
	.base_name   (base_name),
	.ext_name    (ext_name),
	.matches_res (matches_res)
);
